// ===== rtl/ncrw_pkg.sv =====
// Package for the NV12 chroma reorder writer.
// Payload structs, configuration struct, register indexes and widths.
// No dependencies.
package ncrw_pkg;

  localparam int unsigned MaxStride = 4096;
  localparam int unsigned MaxRows   = 4096;

  localparam int unsigned RegW  = 13;
  localparam int unsigned ColW  = $clog2(MaxStride);
  localparam int unsigned RowW  = 13;
  localparam int unsigned AddrW = 25;
  localparam int unsigned IdxW  = 3;

  // register indexes
  localparam logic [IdxW-1:0] RegTargetMode   = 3'd0;
  localparam logic [IdxW-1:0] RegActiveWidth  = 3'd1;
  localparam logic [IdxW-1:0] RegActiveHeight = 3'd2;
  localparam logic [IdxW-1:0] RegSrcStride    = 3'd3;
  localparam logic [IdxW-1:0] RegSrcRows      = 3'd4;
  localparam logic [IdxW-1:0] RegDstStride    = 3'd5;
  localparam logic [IdxW-1:0] RegDstRows      = 3'd6;

  // target modes
  localparam logic ModeNv21 = 1'b0;
  localparam logic ModeI420 = 1'b1;

  localparam logic [RegW-1:0]  RstActiveWidth  = 13'd1920;
  localparam logic [RegW-1:0]  RstActiveHeight = 13'd1080;
  localparam logic [RegW-1:0]  RstSrcStride    = 13'd1920;
  localparam logic [RegW-1:0]  RstSrcRows      = 13'd1080;
  localparam logic [RegW-1:0]  RstDstStride    = 13'd1920;
  localparam logic [RegW-1:0]  RstDstRows      = 13'd1080;
  localparam logic [AddrW-1:0] RstChromaBase   = 25'd2073600;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       frame_start;
  } in_t;

  typedef struct packed {
    logic             write_enable;
    logic [AddrW-1:0] dest_address;
    logic [7:0]       data_byte;
    logic             frame_end;
  } out_t;

  // configuration as seen by the address generator
  typedef struct packed {
    logic             target_mode;
    logic [RegW-1:0]  active_width;
    logic [RegW-1:0]  active_height;
    logic [RegW-1:0]  stride;      // clamped, never zero
    logic [RowW-1:0]  luma_rows;   // clamped
    logic [RowW-1:0]  last_row;
    logic [RegW-1:0]  dst_stride;
    logic [AddrW-1:0] chroma_base;
  } cfg_t;

endpackage

// ===== rtl/ncrw_cfg_regs.sv =====
// Configuration registers of the NV12 chroma reorder writer.
// Holds the geometry, derives clamped values and the chroma plane offset.
// Depends on ncrw_pkg.
module ncrw_cfg_regs (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [ncrw_pkg::IdxW-1:0] cfg_index_i,
  input  logic [ncrw_pkg::RegW-1:0] cfg_wdata_i,
  output ncrw_pkg::cfg_t           cfg_o
);
  import ncrw_pkg::*;

  logic             target_mode_q;
  logic [RegW-1:0]  active_width_q, active_height_q, src_stride_q, src_rows_q;
  logic [RegW-1:0]  dst_stride_q, dst_rows_q;
  logic [AddrW-1:0] chroma_base_q, chroma_base_d;
  logic [2*RegW-1:0] prod;
  logic [RegW-1:0]  mul_a, mul_b;
  logic [RowW-1:0]  luma_rows, total_rows;
  logic [RegW-1:0]  stride;

  // chroma base is dst_stride*dst_rows, computed when either factor is written
  always_comb begin
    mul_a = dst_stride_q;
    mul_b = dst_rows_q;
    if (cfg_index_i == RegDstStride) begin
      mul_a = cfg_wdata_i;
    end else if (cfg_index_i == RegDstRows) begin
      mul_b = cfg_wdata_i;
    end
    prod = (2*RegW)'(mul_a) * (2*RegW)'(mul_b);
    chroma_base_d = chroma_base_q;
    if (cfg_we_i && (cfg_index_i == RegDstStride || cfg_index_i == RegDstRows)) begin
      chroma_base_d = prod[AddrW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_mode_q   <= ModeNv21;
      active_width_q  <= RstActiveWidth;
      active_height_q <= RstActiveHeight;
      src_stride_q    <= RstSrcStride;
      src_rows_q      <= RstSrcRows;
      dst_stride_q    <= RstDstStride;
      dst_rows_q      <= RstDstRows;
      chroma_base_q   <= RstChromaBase;
    end else begin
      chroma_base_q <= chroma_base_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegTargetMode:   target_mode_q   <= cfg_wdata_i[0];
          RegActiveWidth:  active_width_q  <= cfg_wdata_i;
          RegActiveHeight: active_height_q <= cfg_wdata_i;
          RegSrcStride:    src_stride_q    <= cfg_wdata_i;
          RegSrcRows:      src_rows_q      <= cfg_wdata_i;
          RegDstStride:    dst_stride_q    <= cfg_wdata_i;
          RegDstRows:      dst_rows_q      <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    if (src_stride_q > RegW'(MaxStride)) begin
      stride = RegW'(MaxStride);
    end else if (src_stride_q == '0) begin
      stride = RegW'(1);
    end else begin
      stride = src_stride_q;
    end
    luma_rows  = (src_rows_q > RegW'(MaxRows)) ? RowW'(MaxRows) : src_rows_q;
    total_rows = luma_rows + (luma_rows >> 1);

    cfg_o.target_mode   = target_mode_q;
    cfg_o.active_width  = active_width_q;
    cfg_o.active_height = active_height_q;
    cfg_o.stride        = stride;
    cfg_o.luma_rows     = luma_rows;
    cfg_o.last_row      = (total_rows == '0) ? '0 : total_rows - RowW'(1);
    cfg_o.dst_stride    = dst_stride_q;
    cfg_o.chroma_base   = chroma_base_q;
  end

endmodule

// ===== rtl/ncrw_addr_gen.sv =====
// Address generator: column/row counters, running row base and the
// per-byte destination address, write enable and frame end.
// Depends on ncrw_pkg.
module ncrw_addr_gen (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  ncrw_pkg::in_t  in_data_i,
  input  ncrw_pkg::cfg_t cfg_i,
  output ncrw_pkg::out_t res_o
);
  import ncrw_pkg::*;

  logic [ColW-1:0]  col_q, col_d, col;
  logic [RowW-1:0]  row_q, row_d, row, cr, next_row;
  logic [AddrW-1:0] base_q, base_d, base;
  logic [AddrW-1:0] offset, addend, addr;
  logic [RegW-1:0]  col_p1;
  logic             is_luma, we, row_end, frame_end, i420;

  always_comb begin
    col  = in_data_i.frame_start ? '0 : col_q;
    row  = in_data_i.frame_start ? '0 : row_q;
    base = in_data_i.frame_start ? '0 : base_q;

    is_luma = row < cfg_i.luma_rows;
    cr      = row - cfg_i.luma_rows;
    i420    = cfg_i.target_mode == ModeI420;

    if (is_luma) begin
      we = (row < cfg_i.active_height) && (RegW'(col) < cfg_i.active_width);
    end else begin
      we = (cr < (cfg_i.active_height >> 1)) &&
           (RegW'(col) < {cfg_i.active_width[RegW-1:1], 1'b0});
    end

    // chroma: NV21 swaps each pair, I420 splits U/V into two half-width planes
    addend = '0;
    if (is_luma) begin
      offset = AddrW'(col);
    end else if (!i420) begin
      offset = AddrW'({col[ColW-1:1], ~col[0]});
    end else begin
      offset = AddrW'(col >> 1);
      if (col[0]) begin
        addend = cfg_i.chroma_base >> 2;
      end
    end
    addr = base + offset + addend;

    col_p1    = RegW'(col) + RegW'(1);
    row_end   = col_p1 >= cfg_i.stride;
    frame_end = row_end && (row >= cfg_i.last_row);
    next_row  = row + RowW'(1);

    col_d  = col_q;
    row_d  = row_q;
    base_d = base_q;
    if (step_i) begin
      if (frame_end) begin
        col_d  = '0;
        row_d  = '0;
        base_d = '0;
      end else if (row_end) begin
        col_d = '0;
        row_d = next_row;
        if (next_row < cfg_i.luma_rows) begin
          base_d = base + AddrW'(cfg_i.dst_stride);
        end else if (next_row == cfg_i.luma_rows) begin
          base_d = cfg_i.chroma_base;
        end else if (i420) begin
          base_d = base + AddrW'(cfg_i.dst_stride >> 1);
        end else begin
          base_d = base + AddrW'(cfg_i.dst_stride);
        end
      end else begin
        col_d = col_p1[ColW-1:0];
        row_d = row;
        base_d = base;
      end
    end

    res_o.write_enable = we;
    res_o.dest_address = we ? addr : '0;
    res_o.data_byte    = in_data_i.pixel_byte;
    res_o.frame_end    = frame_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      base_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      base_q <= base_d;
    end
  end

endmodule

// ===== rtl/ncrw_out_skid.sv =====
// Output register with a skid stage for the result channel.
// Keeps the input side ready while one result waits on a stalled receiver.
// Depends on ncrw_pkg.
module ncrw_out_skid (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ncrw_pkg::out_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ncrw_pkg::out_t out_data_o
);
  import ncrw_pkg::*;

  logic out_valid_q, skid_valid_q;
  out_t out_q, skid_q;
  logic in_fire, out_free;

  assign in_ready_o  = !skid_valid_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : in_data_i;
    end else if (in_fire) begin
      skid_q <= in_data_i;
    end
  end

endmodule

// ===== rtl/nv12_chroma_reorder_writer_unit.sv =====
// NV12 chroma reorder writer, top level.
// Takes source bytes of a padded NV12 frame on the input channel, one per
// transfer, and returns for each one a result: write enable, destination
// address, the byte itself and a frame end flag. Luma is copied to the
// destination stride; chroma becomes NV21 (pairs swapped) or planar I420.
// Results are registered, in the skid stage on a stall. Throughput: one byte
// per cycle while the receiver takes results; the address path is one adder
// chain on the row base, and the chroma plane offset (dst_stride*dst_rows) is
// multiplied when a register is written, so it never sits in the byte path.
// Configuration is a write-only port; write it only while no byte is in
// flight. Reset restores the default 1920x1080 geometry in NV21 mode and
// clears the counters. A stalled receiver holds one result in the output
// register and one more in the skid stage; input ready drops only when
// both are full. frame_start on a byte restarts the counters at offset zero.
// Depends on ncrw_pkg, ncrw_cfg_regs, ncrw_addr_gen, ncrw_out_skid.
module nv12_chroma_reorder_writer_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  ncrw_pkg::in_t             in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output ncrw_pkg::out_t            out_data_o,
  input  logic                      cfg_we_i,
  input  logic [ncrw_pkg::IdxW-1:0] cfg_index_i,
  input  logic [ncrw_pkg::RegW-1:0] cfg_wdata_i
);
  import ncrw_pkg::*;

  cfg_t cfg;
  out_t res;
  logic in_fire;

  assign in_fire = in_valid_i && in_ready_o;

  ncrw_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ncrw_addr_gen u_addr (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (in_fire),
    .in_data_i (in_data_i),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  ncrw_out_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
